[rtl/rif_pkg.sv]
// ----------------------------------------------------------------------------
// rif_pkg
// Shared types and constants of the time-reversed IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rif_pkg;

  // Coefficient format: signed Q4.28 in a 32-bit word
  localparam int COEF_BITS  = 32;
  localparam int FRAC_BITS  = 28;
  localparam int AUX_BITS   = 32;
  localparam int PROD_BITS  = COEF_BITS + AUX_BITS;
  // Four products and the scaled sample never need more than 68 bits
  localparam int ACC_BITS   = PROD_BITS + 4;
  // Width left after the rounding shift
  localparam int Q_BITS     = ACC_BITS - FRAC_BITS;

  localparam int MAX_TAPS   = 4;
  localparam int HIST_DEPTH = MAX_TAPS - 1;
  localparam int TAP_BITS   = $clog2(MAX_TAPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam int REG_IDX_BITS = 3;

  localparam logic [COEF_BITS-1:0] FF0_RESET = 32'h1000_0000;
  localparam logic [COEF_BITS-1:0] COEF_ZERO = '0;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_FF0 = 3'd0,
    REG_FF1 = 3'd1,
    REG_FF2 = 3'd2,
    REG_FF3 = 3'd3,
    REG_FB1 = 3'd4,
    REG_FB2 = 3'd5,
    REG_FB3 = 3'd6
  } reg_idx_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    logic start;
  } item_ctl_t;

endpackage

`default_nettype wire

[rtl/rif_cfg.sv]
// ----------------------------------------------------------------------------
// rif_cfg
// Coefficient register file, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rif_cfg (
  input  logic                                                      clk,
  input  logic                                                      rst,
  input  logic                                                      cfg_valid,
  output logic                                                      cfg_ready,
  input  logic [rif_pkg::REG_IDX_BITS-1:0]                          cfg_index,
  input  logic [rif_pkg::COEF_BITS-1:0]                             cfg_data,
  output logic [rif_pkg::MAX_TAPS-1:0][rif_pkg::COEF_BITS-1:0]      ff_coef,
  output logic [rif_pkg::HIST_DEPTH-1:0][rif_pkg::COEF_BITS-1:0]    fb_coef
);

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_coef[0] <= rif_pkg::FF0_RESET;
      ff_coef[1] <= rif_pkg::COEF_ZERO;
      ff_coef[2] <= rif_pkg::COEF_ZERO;
      ff_coef[3] <= rif_pkg::COEF_ZERO;
      fb_coef[0] <= rif_pkg::COEF_ZERO;
      fb_coef[1] <= rif_pkg::COEF_ZERO;
      fb_coef[2] <= rif_pkg::COEF_ZERO;
    end else if (wr) begin
      case (cfg_index)
        rif_pkg::REG_FF0: ff_coef[0] <= cfg_data;
        rif_pkg::REG_FF1: ff_coef[1] <= cfg_data;
        rif_pkg::REG_FF2: ff_coef[2] <= cfg_data;
        rif_pkg::REG_FF3: ff_coef[3] <= cfg_data;
        rif_pkg::REG_FB1: fb_coef[0] <= cfg_data;
        rif_pkg::REG_FB2: fb_coef[1] <= cfg_data;
        rif_pkg::REG_FB3: fb_coef[2] <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/rif_front.sv]
// ----------------------------------------------------------------------------
// rif_front
// Input side: takes sample words, tags block starts and queues them for
// the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rif_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  sample,
  input  logic                    block_start,
  output rif_pkg::item_ctl_t      item,
  output logic [SAMPLE_BITS-1:0]  item_sample,
  input  logic                    item_pop
);

  localparam logic [rif_pkg::PTR_BITS-1:0] LAST_PTR =
    rif_pkg::PTR_BITS'(rif_pkg::QUEUE_DEPTH - 1);
  localparam logic [rif_pkg::CNT_BITS-1:0] FULL_CNT =
    rif_pkg::CNT_BITS'(rif_pkg::QUEUE_DEPTH);

  logic [SAMPLE_BITS-1:0]        q_sample [rif_pkg::QUEUE_DEPTH];
  logic                          q_start  [rif_pkg::QUEUE_DEPTH];
  logic [rif_pkg::PTR_BITS-1:0]  wr_ptr;
  logic [rif_pkg::PTR_BITS-1:0]  rd_ptr;
  logic [rif_pkg::CNT_BITS-1:0]  count;
  logic                          push;

  assign in_stall    = (count == FULL_CNT);
  assign push        = in_valid && !in_stall;
  assign item.valid  = (count != '0);
  assign item.start  = q_start[rd_ptr];
  assign item_sample = q_sample[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_sample[wr_ptr] <= sample;
      q_start[wr_ptr]  <= block_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (item_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, item_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/rif_back.sv]
// ----------------------------------------------------------------------------
// rif_back
// Arithmetic back end: one shared 32x32 multiplier walks the feedback taps,
// rounds and saturates the auxiliary value, walks the feed-forward taps and
// delivers the rounded and saturated output word.
// ----------------------------------------------------------------------------
`default_nettype none

module rif_back #(
  parameter int TAPS        = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  rif_pkg::item_ctl_t                                      item,
  input  logic [SAMPLE_BITS-1:0]                                  item_sample,
  output logic                                                    item_pop,
  input  logic [rif_pkg::MAX_TAPS-1:0][rif_pkg::COEF_BITS-1:0]    ff_coef,
  input  logic [rif_pkg::HIST_DEPTH-1:0][rif_pkg::COEF_BITS-1:0]  fb_coef,
  output logic                                                    out_valid,
  input  logic                                                    out_stall,
  output logic [SAMPLE_BITS-1:0]                                  filtered,
  output logic                                                    clipped
);

  localparam int ACC  = rif_pkg::ACC_BITS;
  localparam int QB   = rif_pkg::Q_BITS;
  localparam int AUX  = rif_pkg::AUX_BITS;
  localparam int FRAC = rif_pkg::FRAC_BITS;
  localparam logic [rif_pkg::TAP_BITS-1:0] LAST_TAP = rif_pkg::TAP_BITS'(TAPS - 1);
  localparam logic [ACC-1:0] HALF = ACC'(1) << (FRAC - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_FB   = 7'b0000010,
    ST_FBD  = 7'b0000100,
    ST_WRND = 7'b0001000,
    ST_FF   = 7'b0010000,
    ST_FFD  = 7'b0100000,
    ST_YRND = 7'b1000000
  } state_t;

  state_t                          state, state_next;
  logic [rif_pkg::TAP_BITS-1:0]    tap;
  logic signed [ACC-1:0]           acc;
  logic signed [rif_pkg::PROD_BITS-1:0] prod;
  logic                            prod_vld;
  logic [AUX-1:0]                  hist [rif_pkg::HIST_DEPTH];
  logic [AUX-1:0]                  w;
  logic                            w_sat;
  logic [rif_pkg::COEF_BITS-1:0]   mul_a;
  logic [AUX-1:0]                  mul_b;
  logic [AUX-1:0]                  hist_sel;
  logic [rif_pkg::COEF_BITS-1:0]   fb_sel;
  logic signed [ACC-1:0]           rnd;
  logic [QB-1:0]                   q;
  logic                            w_fits;
  logic                            y_fits;
  logic [AUX-1:0]                  w_val;
  logic [SAMPLE_BITS-1:0]          y_val;
  logic                            y_go;

  // Tap j reads the auxiliary value j steps back; tap 0 reads the fresh w
  always_comb begin
    case (tap)
      2'd1:    hist_sel = hist[0];
      2'd2:    hist_sel = hist[1];
      2'd3:    hist_sel = hist[2];
      default: hist_sel = w;
    endcase
    case (tap)
      2'd2:    fb_sel = fb_coef[1];
      2'd3:    fb_sel = fb_coef[2];
      default: fb_sel = fb_coef[0];
    endcase
    mul_a = (state == ST_FB) ? fb_sel : ff_coef[tap];
    mul_b = hist_sel;
  end

  // Round half-up and drop the fraction
  assign rnd    = acc + $signed(HALF);
  assign q      = rnd[ACC-1:FRAC];
  assign w_fits = (&q[QB-1:AUX-1]) || !(|q[QB-1:AUX-1]);
  assign y_fits = (&q[QB-1:SAMPLE_BITS-1]) || !(|q[QB-1:SAMPLE_BITS-1]);
  assign w_val  = w_fits ? q[AUX-1:0] : {q[QB-1], {(AUX-1){~q[QB-1]}}};
  assign y_val  = y_fits ? q[SAMPLE_BITS-1:0]
                         : {q[QB-1], {(SAMPLE_BITS-1){~q[QB-1]}}};

  assign y_go     = (state == ST_YRND) && (!out_valid || !out_stall);
  assign item_pop = (state == ST_IDLE) && item.valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item.valid) state_next = (TAPS > 1) ? ST_FB : ST_WRND;
      ST_FB:   if (tap == LAST_TAP) state_next = ST_FBD;
      ST_FBD:  state_next = ST_WRND;
      ST_WRND: state_next = ST_FF;
      ST_FF:   if (tap == LAST_TAP) state_next = ST_FFD;
      ST_FFD:  state_next = ST_YRND;
      ST_YRND: if (y_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
      tap       <= '0;
      for (int i = 0; i < rif_pkg::HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      state    <= state_next;
      prod_vld <= (state == ST_FB) || (state == ST_FF);
      case (state)
        ST_IDLE: begin
          tap <= rif_pkg::TAP_BITS'(1);
          if (item.valid && item.start) begin
            for (int i = 0; i < rif_pkg::HIST_DEPTH; i++) begin
              hist[i] <= '0;
            end
          end
        end
        ST_FB, ST_FF: if (tap != LAST_TAP) tap <= tap + 1'b1;
        ST_WRND: tap <= '0;
        ST_YRND: begin
          if (y_go) begin
            hist[0] <= w;
            for (int i = 1; i < rif_pkg::HIST_DEPTH; i++) begin
              hist[i] <= hist[i-1];
            end
          end
        end
        default: ;
      endcase
      if (y_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: multiplier register, accumulator and result registers
  always_ff @(posedge clk) begin
    prod <= $signed(mul_a) * $signed(mul_b);
    if (item_pop) begin
      acc <= {{(ACC-SAMPLE_BITS-FRAC){item_sample[SAMPLE_BITS-1]}}, item_sample,
              {FRAC{1'b0}}};
    end else if (state == ST_WRND) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + {{(ACC-rif_pkg::PROD_BITS){prod[rif_pkg::PROD_BITS-1]}}, prod};
    end
    if (state == ST_WRND) begin
      w     <= w_val;
      w_sat <= !w_fits;
    end
    if (y_go) begin
      filtered <= y_val;
      clipped  <= w_sat || !y_fits;
    end
  end

endmodule

`default_nettype wire

[rtl/reverse_iir_filter_top.sv]
// ----------------------------------------------------------------------------
// reverse_iir_filter_top
// Time-reversed direct form II IIR filter, Q4.28 coefficients.
// ----------------------------------------------------------------------------
// Samples of a block are presented last to first; block_start on the first
// word clears the three-entry history. A two-word queue takes input words
// while the back end works, and an output register holds the finished word
// so the next sample can proceed under output stall. The back end takes one
// sample at a time: it loads the sample, then the single registered 32x32
// multiplier serves the TAPS-1 feedback products and then the TAPS
// feed-forward products in turn, with a drain and a round step after each
// pass; at TAPS = 1 the feedback pass and its drain step drop out.
// Coefficient writes are taken at any time on the cfg channel and must only
// arrive while the filter is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module reverse_iir_filter_top #(
  parameter int TAPS        = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic                                block_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [SAMPLE_BITS-1:0]              filtered,
  output logic                                clipped,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rif_pkg::REG_IDX_BITS-1:0]    cfg_index,
  input  logic [rif_pkg::COEF_BITS-1:0]       cfg_data
);

  logic [rif_pkg::MAX_TAPS-1:0][rif_pkg::COEF_BITS-1:0]   ff_coef;
  logic [rif_pkg::HIST_DEPTH-1:0][rif_pkg::COEF_BITS-1:0] fb_coef;
  rif_pkg::item_ctl_t                                     item;
  logic [SAMPLE_BITS-1:0]                                 item_sample;
  logic                                                   item_pop;

  rif_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ff_coef   (ff_coef),
    .fb_coef   (fb_coef)
  );

  rif_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .block_start (block_start),
    .item        (item),
    .item_sample (item_sample),
    .item_pop    (item_pop)
  );

  rif_back #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .item_sample (item_sample),
    .item_pop    (item_pop),
    .ff_coef     (ff_coef),
    .fb_coef     (fb_coef),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .filtered    (filtered),
    .clipped     (clipped)
  );

endmodule

`default_nettype wire

[rtl/rif_checker.sv]
// ----------------------------------------------------------------------------
// rif_checker
// Port-level checks of the filter: output hold and word accounting.
// ----------------------------------------------------------------------------
`default_nettype none

module rif_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [SAMPLE_BITS-1:0]  filtered,
  input  logic                    clipped
);

  // Queue, back end and output register together hold this many words
  localparam logic [2:0] MAX_PEND  = 3'(rif_pkg::QUEUE_DEPTH + 2);
  localparam logic [2:0] QUEUE_CNT = 3'(rif_pkg::QUEUE_DEPTH);

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(filtered) && $stable(clipped))
    else $error("output word changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("output word without a pending sample");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= MAX_PEND)
    else $error("more words in flight than the filter can hold");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> pending >= QUEUE_CNT)
    else $error("input stalled with room in the queue");

endmodule

bind reverse_iir_filter_top rif_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rif_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .filtered  (filtered),
  .clipped   (clipped)
);

`default_nettype wire
